// ===== design/gmsb_pkg.sv =====
// gmsb_pkg: shared constants for the grid multi-source bfs block
// used by the top level and the column remainder unit
package gmsb_pkg;

  localparam int DIM_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int LEVEL_W      = 12;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 16;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_SOURCE = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_SAT = {LEVEL_W{1'b1}};

endpackage

// ===== design/gmsb_colrem.sv =====
// gmsb_colrem: serial remainder unit, one dividend bit per cycle
// gives cell index modulo column count; depends on gmsb_pkg
module gmsb_colrem #(
  parameter int IW = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [IW-1:0]            dividend,
  input  logic [gmsb_pkg::DIM_W-1:0] divisor,
  output logic                     done,
  output logic [gmsb_pkg::DIM_W-1:0] rem
);
  import gmsb_pkg::*;

  localparam int CNT_W = $clog2(IW + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0]    sh_r, sh_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, sh_r[IW-1]};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(IW);
      sh_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = trial[DIM_W-1:0];
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign rem  = rem_r;

endmodule

// ===== design/grid_multi_source_bfs_time.sv =====
// grid_multi_source_bfs_time: grid load plus level-by-level bfs over two memories
// depends on gmsb_pkg and gmsb_colrem
//
// Cells load one per cycle in raster order into a target map and a frontier
// queue memory. On the beat with tlast the search runs while in_tready is low:
// each dequeued cell is read from the queue and its column found in the serial
// column remainder unit, then each direction is tried, with a further step per
// in-range loaded neighbour (map read, then write back and enqueue).
// One result beat follows; the next grid may load while it waits to be taken.
// Geometry is sampled at the last cell. No clearing pass is needed after reset.
module grid_multi_source_bfs_time #(
  parameter int MAX_ROWS = gmsb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmsb_pkg::DEF_MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gmsb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gmsb_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gmsb_pkg::IN_DATA_W-1:0]  in_tdata,   // [1:0] cell_kind
  input  logic                            in_tlast,   // last_cell
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gmsb_pkg::OUT_DATA_W-1:0] out_tdata,  // [11:0] levels
  output logic                            out_tuser   // unreachable
);
  import gmsb_pkg::*;

  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int PW  = IW + 1;
  localparam int EW  = IW + DIM_W + 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_LVL  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_NB   = 3'd5;
  localparam logic [2:0] S_NCK  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] d;
    d = v;
    if (v == '0) d = DIM_W'(1);
    else if (int'(v) > maxv) d = DIM_W'(maxv);
    return d;
  endfunction

  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [2:0]         state_r, state_nxt;
  logic [PW-1:0]      lp_r, lp_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0]      rem_r, rem_nxt, left_r, left_nxt;
  logic [PW-1:0]      s_cap_r, s_cap_nxt;
  logic [DIM_W-1:0]   s_cols_r, s_cols_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt, res_lv_r, res_lv_nxt;
  logic               res_unr_r, res_unr_nxt;
  logic [IW-1:0]      idx_r, idx_nxt, nidx_r, nidx_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic               ov_r, ov_nxt;
  logic [LEVEL_W-1:0] olv_r, olv_nxt;
  logic               ounr_r, ounr_nxt;

  logic [DIM_W-1:0]   c_rows, c_cols;
  logic [2*DIM_W-1:0] cap_prod;
  logic [PW-1:0]      cap_now;

  logic               open_mem [CAP];
  logic [IW-1:0]      q_mem [CAP];
  logic               open_we, open_wd, open_rd_r;
  logic [IW-1:0]      open_wa, open_ra;
  logic               q_we;
  logic [IW-1:0]      q_wa, q_wd, q_ra, q_rd_r;

  logic               div_start, div_done;
  logic [DIM_W-1:0]   div_rem;

  logic               in_beat;
  logic [1:0]         kind;
  logic               nvalid;
  logic [EW-1:0]      idx_e, cols_e, n_e;

  gmsb_colrem #(.IW(IW)) u_colrem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_rd_r),
    .divisor  (s_cols_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign c_rows   = clamp_dim(rows_r, MAX_ROWS);
  assign c_cols   = clamp_dim(cols_r, MAX_COLS);
  assign cap_prod = c_rows * c_cols;
  assign cap_now  = PW'(cap_prod);
  assign kind     = in_tdata[1:0];
  assign in_tready = (state_r == S_LOAD);
  assign in_beat  = in_tvalid && in_tready;
  assign idx_e    = EW'(idx_r);
  assign cols_e   = EW'(s_cols_r);

  always_comb begin
    nvalid = 1'b0;
    n_e    = idx_e;
    case (dir_r)
      2'd0: begin
        nvalid = idx_e >= cols_e;
        n_e    = idx_e - cols_e;
      end
      2'd1: begin
        nvalid = (idx_e + cols_e) < EW'(s_cap_r);
        n_e    = idx_e + cols_e;
      end
      2'd2: begin
        nvalid = col_r != '0;
        n_e    = idx_e - EW'(1);
      end
      default: begin
        nvalid = ({1'b0, col_r} + 1'b1) < {1'b0, s_cols_r};
        n_e    = idx_e + EW'(1);
      end
    endcase
    nvalid = nvalid && (n_e < EW'(lp_r));
  end

  always_comb begin
    state_nxt   = state_r;
    lp_nxt      = lp_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    rem_nxt     = rem_r;
    left_nxt    = left_r;
    s_cap_nxt   = s_cap_r;
    s_cols_nxt  = s_cols_r;
    lvl_nxt     = lvl_r;
    res_lv_nxt  = res_lv_r;
    res_unr_nxt = res_unr_r;
    idx_nxt     = idx_r;
    nidx_nxt    = nidx_r;
    col_nxt     = col_r;
    dir_nxt     = dir_r;
    ov_nxt      = ov_r && !out_tready;
    olv_nxt     = olv_r;
    ounr_nxt    = ounr_r;
    open_we     = 1'b0;
    open_wa     = nidx_r;
    open_wd     = 1'b0;
    open_ra     = IW'(n_e);
    q_we        = 1'b0;
    q_wa        = tail_r[IW-1:0];
    q_wd        = nidx_r;
    q_ra        = head_r[IW-1:0];
    div_start   = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_beat) begin
          if (lp_r < cap_now) begin
            open_we = 1'b1;
            open_wa = lp_r[IW-1:0];
            open_wd = (kind == KIND_TARGET);
            if (kind == KIND_SOURCE) begin
              q_we     = 1'b1;
              q_wd     = lp_r[IW-1:0];
              tail_nxt = tail_r + 1'b1;
            end else if (kind == KIND_TARGET) begin
              rem_nxt = rem_r + 1'b1;
            end
            lp_nxt = lp_r + 1'b1;
          end
          if (in_tlast) begin
            s_cap_nxt  = cap_now;
            s_cols_nxt = c_cols;
            lvl_nxt    = '0;
            state_nxt  = S_LVL;
          end
        end
      end
      S_LVL: begin
        if (head_r == tail_r) begin
          res_lv_nxt  = '0;
          res_unr_nxt = (rem_r != '0);
          state_nxt   = S_FIN;
        end else if (rem_r == '0) begin
          res_lv_nxt  = lvl_r;
          res_unr_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          left_nxt  = tail_r - head_r;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (left_r == '0) begin
          if (lvl_r != LEVEL_SAT) lvl_nxt = lvl_r + 1'b1;
          state_nxt = S_LVL;
        end else begin
          head_nxt  = head_r + 1'b1;
          left_nxt  = left_r - 1'b1;
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        div_start = 1'b1;
        idx_nxt   = q_rd_r;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          col_nxt   = div_rem;
          dir_nxt   = 2'd0;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (nvalid) begin
          nidx_nxt  = IW'(n_e);
          state_nxt = S_NCK;
        end else if (dir_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_NCK: begin
        if (open_rd_r) begin
          open_we  = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
          if (rem_r != '0) rem_nxt = rem_r - 1'b1;
        end
        if (dir_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 1'b1;
          state_nxt = S_NB;
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          olv_nxt   = res_lv_r;
          ounr_nxt  = res_unr_r;
          lp_nxt    = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          rem_nxt   = '0;
          left_nxt  = '0;
          lvl_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_rd_r <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(MAX_ROWS);
      cols_r  <= DIM_W'(MAX_COLS);
      state_r <= S_LOAD;
      lp_r    <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      rem_r   <= '0;
      left_r  <= '0;
      lvl_r   <= '0;
      dir_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == REG_ROWS) rows_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_COLS) cols_r <= cfg_wdata;
      state_r <= state_nxt;
      lp_r    <= lp_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      rem_r   <= rem_nxt;
      left_r  <= left_nxt;
      lvl_r   <= lvl_nxt;
      dir_r   <= dir_nxt;
      ov_r    <= ov_nxt;
    end
    s_cap_r   <= s_cap_nxt;
    s_cols_r  <= s_cols_nxt;
    res_lv_r  <= res_lv_nxt;
    res_unr_r <= res_unr_nxt;
    idx_r     <= idx_nxt;
    nidx_r    <= nidx_nxt;
    col_r     <= col_nxt;
    olv_r     <= olv_nxt;
    ounr_r    <= ounr_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_DATA_W'(olv_r);
  assign out_tuser  = ounr_r;

endmodule

// ===== design/gmsb_checker.sv =====
// gmsb_checker: port-level assertions for grid_multi_source_bfs_time
// depends on gmsb_pkg; bound to the top level below
module gmsb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gmsb_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import gmsb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[LEVEL_W-1:0] == '0)
    else $error("unreachable result with nonzero levels");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:LEVEL_W] == '0)
    else $error("padding bits of result beat not zero");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind grid_multi_source_bfs_time gmsb_checker u_gmsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/tb_grid_multi_source_bfs_time.sv =====
// tb_grid_multi_source_bfs_time: self-checking bench for the grid bfs block
// streams grids cell by cell, predicts level count or unreachable flag per grid
// depends on gmsb_pkg and grid_multi_source_bfs_time
module tb_grid_multi_source_bfs_time;
  timeunit 1ns;
  timeprecision 1ps;
  import gmsb_pkg::*;

  localparam int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic               unreachable;
  } bfs_result_t;

  typedef enum logic [1:0] {ROW_CELL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [1:0]           cell_kind;
    logic                 last;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     value;
    bit                   typed;
    bfs_result_t          want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [DIM_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [1:0] cell_kind
  logic                  in_tlast;   // last_cell
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [11:0] levels
  logic                  out_tuser;  // unreachable

  grid_multi_source_bfs_time i_dut (.*);

  always #6 clk = ~clk;

  // grid model state
  logic [1:0]   cell_mem [CELLS];
  bit           seen_map [CELLS];
  int           frontier [CELLS];
  int           q_head, q_tail, targets_left, load_pos;
  logic [DIM_W-1:0] rows_reg, cols_reg;

  bfs_result_t  result_q [$];
  int           errors;
  bit           no_idle;
  bit           hold_req;

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function void enqueue(int idx);
    if (q_tail < CELLS) begin
      frontier[q_tail] = idx;
      q_tail++;
    end
  endfunction

  function void spread_to(int idx);
    if (idx < load_pos && idx < CELLS && !seen_map[idx] && cell_mem[idx] == KIND_TARGET) begin
      seen_map[idx] = 1'b1;
      if (targets_left > 0) targets_left--;
      enqueue(idx);
    end
  endfunction

  function bfs_result_t run_bfs(int rows, int cols);
    bfs_result_t res;
    int lvl, width, idx, r, c;
    lvl = 0;
    res = '0;
    while (q_head != q_tail) begin
      if (targets_left == 0) begin
        res.levels = (lvl > LEVEL_SAT) ? LEVEL_SAT : lvl[LEVEL_W-1:0];
        return res;
      end
      width = q_tail - q_head;
      while (width > 0) begin
        idx = frontier[q_head];
        r = idx / cols;
        c = idx % cols;
        q_head++;
        width--;
        if (r > 0) spread_to(idx - cols);
        if (r + 1 < rows) spread_to(idx + cols);
        if (c > 0) spread_to(idx - 1);
        if (c + 1 < cols) spread_to(idx + 1);
      end
      if (lvl < LEVEL_SAT) lvl++;
    end
    res.unreachable = (targets_left != 0);
    return res;
  endfunction

  // returns 1 when the beat closes a grid
  function bit load_beat(logic [1:0] k, logic l, output bfs_result_t res);
    int rows, cols;
    rows = clamp_dim(rows_reg, DEF_MAX_ROWS);
    cols = clamp_dim(cols_reg, DEF_MAX_COLS);
    res = '0;
    if (load_pos < rows * cols) begin
      cell_mem[load_pos] = k;
      seen_map[load_pos] = (k == KIND_SOURCE);
      if (k == KIND_SOURCE) enqueue(load_pos);
      else if (k == KIND_TARGET) targets_left++;
      load_pos++;
    end
    if (!l) return 1'b0;
    res = run_bfs(rows, cols);
    q_head = 0;
    q_tail = 0;
    targets_left = 0;
    load_pos = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    wait (result_q.size() == 0);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ROWS) rows_reg = value;
    else rows_reg = rows_reg;
    if (idx == REG_COLS) cols_reg = value;
  endtask

  task automatic send_cell(logic [1:0] k, logic l, bit typed, bfs_result_t want);
    bfs_result_t res;
    repeat (no_idle ? 0 : $urandom_range(0, 9)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {{(IN_DATA_W-2){1'b0}}, k};
    in_tlast = l;
    do @(posedge clk); while (!in_tready);
    if (load_beat(k, l, res)) result_q.push_back(typed ? want : res);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    bfs_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 0);
      end else begin
        want = result_q.pop_front();
        if (out_tdata !== {{(OUT_DATA_W-LEVEL_W){1'b0}}, want.levels})
          report_mismatch("levels", out_tdata, want.levels);
        if (out_tuser !== want.unreachable)
          report_mismatch("unreachable", out_tuser, want.unreachable);
      end
    end
  end

  // result receiver
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_tready = 1'b0;
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (20000) @(negedge clk);
      end else begin
        repeat (no_idle ? 0 : $urandom_range(0, 9)) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  plan_row_t plan [$];

  function automatic plan_row_t cell_row(logic [1:0] k, logic l, bit typed = 0,
                                         int lv = 0, bit unr = 0);
    plan_row_t p;
    p = '{kind: ROW_CELL, cell_kind: k, last: l, idx: REG_ROWS, value: '0, typed: typed,
          want: '{levels: lv[LEVEL_W-1:0], unreachable: unr}};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int v);
    plan_row_t p;
    p = '{kind: ROW_CFG, cell_kind: '0, last: 1'b0, idx: idx, value: v[DIM_W-1:0],
          typed: 0, want: '0};
    return p;
  endfunction

  initial begin
    int items, grids, rows, cols, cap, n, mode, pick;
    logic [1:0] k;
    plan_row_t p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    errors = 0;
    no_idle = 0;
    hold_req = 0;
    q_head = 0;
    q_tail = 0;
    targets_left = 0;
    load_pos = 0;
    rows_reg = DIM_W'(DEF_MAX_ROWS);
    cols_reg = DIM_W'(DEF_MAX_COLS);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // after reset, single cell grids on the default geometry
    plan.push_back(cell_row(KIND_SOURCE, 1, 1, 0, 0));
    plan.push_back(cell_row(KIND_TARGET, 1, 1, 0, 1));
    plan.push_back(cell_row(2'd0, 1, 1, 0, 0));
    // zero rows acts as one, a 1x3 strip
    plan.push_back(cfg_row(REG_ROWS, 0));
    plan.push_back(cfg_row(REG_COLS, 3));
    plan.push_back(cell_row(KIND_SOURCE, 0));
    plan.push_back(cell_row(KIND_TARGET, 0));
    plan.push_back(cell_row(KIND_TARGET, 1, 1, 2, 0));
    // kind three blocks like empty
    plan.push_back(cell_row(KIND_TARGET, 0));
    plan.push_back(cell_row(2'd3, 0));
    plan.push_back(cell_row(KIND_SOURCE, 1, 1, 0, 1));
    // cells past the grid are dropped
    plan.push_back(cfg_row(REG_COLS, 1));
    plan.push_back(cell_row(KIND_SOURCE, 0));
    plan.push_back(cell_row(KIND_TARGET, 0));
    plan.push_back(cell_row(KIND_TARGET, 1, 1, 0, 0));
    // geometry change while a grid is half loaded
    plan.push_back(cfg_row(REG_ROWS, 2));
    plan.push_back(cfg_row(REG_COLS, 2));
    plan.push_back(cell_row(KIND_SOURCE, 0));
    plan.push_back(cell_row(KIND_TARGET, 0));
    plan.push_back(cfg_row(REG_ROWS, 127));
    plan.push_back(cfg_row(REG_COLS, 1));
    plan.push_back(cell_row(KIND_TARGET, 0));
    plan.push_back(cell_row(KIND_TARGET, 1));

    items = 0;
    foreach (plan[i]) begin
      p = plan[i];
      if (p.kind == ROW_CFG) begin
        write_reg(p.idx, p.value);
      end else begin
        send_cell(p.cell_kind, p.last, p.typed, p.want);
        items++;
      end
    end

    grids = 0;
    while (items < 1050) begin
      if (grids % 6 == 0) begin
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          rows = $urandom_range(0, 1) ? 127 : 64;
          cols = $urandom_range(0, 2);
        end else if (pick == 1) begin
          rows = $urandom_range(0, 2);
          cols = $urandom_range(0, 1) ? 127 : $urandom_range(9, 126);
        end else begin
          rows = $urandom_range(1, 8);
          cols = $urandom_range(1, 8);
        end
        write_reg(REG_ROWS, rows[DIM_W-1:0]);
        write_reg(REG_COLS, cols[DIM_W-1:0]);
      end
      if (grids == 7) hold_req = 1'b1;
      if (grids == 20) wait (result_q.size() == 0);
      no_idle = (grids >= 10 && grids < 16) || (grids >= 30 && grids < 36);
      cap = clamp_dim(rows_reg, DEF_MAX_ROWS) * clamp_dim(cols_reg, DEF_MAX_COLS);
      mode = $urandom_range(0, 9);
      if (mode == 0) n = $urandom_range(1, cap);
      else if (mode == 1) n = cap + $urandom_range(1, 3);
      else n = cap;
      for (int c = 0; c < n; c++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) k = KIND_SOURCE;
        else if (pick < 70) k = KIND_TARGET;
        else if (pick < 94) k = 2'd0;
        else k = 2'd3;
        send_cell(k, c == n - 1, 0, '0);
        items++;
      end
      grids++;
    end
    no_idle = 0;

    wait (result_q.size() == 0);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
